FILE: rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg: shared constants, types and helpers
// Widths, sign codes, state encoding and the alphabet lookup used by the
// radix formatter and its serial units.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 5;
  localparam int ALPHA_W    = 64;
  localparam int SYM_W      = 8;
  localparam int MAX_RADIX  = 16;
  localparam int DIGIT_W    = $clog2(MAX_RADIX);
  localparam int MAX_DIGITS = VALUE_W;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int CFG_IDX_W  = 2;

  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } srf_state_t;

  // status from the serial divider
  typedef struct packed {
    logic               done;
    logic               quo_zero;
    logic [DIGIT_W-1:0] digit;
  } div_status_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [2*ALPHA_W-1:0] alpha,
                                                  input logic [DIGIT_W-1:0]   idx);
    symbol_at = alpha[idx*SYM_W +: SYM_W];
  endfunction

endpackage

FILE: rtl/srf_divider.sv
// ----------------------------------------------------------------------------
// srf_divider: bit-serial restoring divider
// Divides a 32-bit magnitude by the radix one quotient bit per cycle and
// leaves quotient and remainder digit when done pulses.
// ----------------------------------------------------------------------------
module srf_divider
  import srf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   dividend,
  input  logic [RADIX_W-1:0]   base,
  output logic [VALUE_W-1:0]   quotient,
  output div_status_t          status
);

  logic                 busy;
  logic                 done;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [VALUE_W-1:0]   quo;
  logic [RADIX_W-1:0]   rem;
  logic [RADIX_W-1:0]   rem_sh;
  logic                 ge;

  // shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem[RADIX_W-2:0], quo[VALUE_W-1]};
  assign ge     = (rem_sh >= base);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], ge};
      rem <= ge ? (rem_sh - base) : rem_sh;
    end
  end

  assign quotient        = quo;
  assign status.done     = done;
  assign status.quo_zero = (quo == '0);
  assign status.digit    = rem[DIGIT_W-1:0];

endmodule

FILE: rtl/srf_digit_stack.sv
// ----------------------------------------------------------------------------
// srf_digit_stack: digit shift stack
// Shift-register LIFO; digits enter least significant first and leave most
// significant first from the head position.
// ----------------------------------------------------------------------------
module srf_digit_stack
  import srf_pkg::*;
(
  input  logic               clk,
  input  logic               push,
  input  logic               pop,
  input  logic [DIGIT_W-1:0] din,
  output logic [DIGIT_W-1:0] dout
);

  logic [DIGIT_W-1:0] stack [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= din;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  assign dout = stack[0];

endmodule

FILE: rtl/signed_radix_formatter.sv
// ----------------------------------------------------------------------------
// signed_radix_formatter: signed integer to text in a configured radix
// Converts a signed 32-bit request into alphabet symbols, most significant
// first, with a leading minus for negative values.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------
//   input    | in_valid / in_stall   | value (32b signed)
//   output   | out_valid / out_stall | symbol (8b), last (1b)
//   config   | cfg_write             | cfg_index (2b), cfg_data (64b)
//
// Each digit takes one full pass of the bit-serial divider (32 quotient
// bits and then a done pulse); after the last digit the symbols are
// emitted one per cycle while out_stall stays low.
// Worst case is radix 2: 32 digits plus the sign.
// Reset (rst, synchronous) clears radix and alphabet to zero, which is an
// invalid alphabet; requests with an invalid alphabet are taken and dropped.
// in_stall is high from acceptance until the last symbol is loaded into the
// output register; out_stall holds the output register and the emit state.
// ----------------------------------------------------------------------------
module signed_radix_formatter
  import srf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [ALPHA_W-1:0]          cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VALUE_W-1:0]   value,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SYM_W-1:0]            symbol,
  output logic                        last
);

  // config registers
  logic [RADIX_W-1:0]   radix;
  logic [2*ALPHA_W-1:0] alpha;

  // control
  srf_state_t           state;
  logic                 sign_pend;
  logic [CNT_W-1:0]     cnt;
  logic                 alpha_ok;
  logic                 accept;
  logic                 out_load;
  logic                 neg;
  logic [VALUE_W-1:0]   mag;

  // divider / stack hookup
  logic                 div_start;
  logic [VALUE_W-1:0]   div_dividend;
  logic [VALUE_W-1:0]   div_quo;
  div_status_t          div_st;
  logic                 push;
  logic                 pop;
  logic [DIGIT_W-1:0]   top_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
      alpha <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:      radix <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha[ALPHA_W-1:0] <= cfg_data;
        REG_ALPHA_HIGH: alpha[2*ALPHA_W-1:ALPHA_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Alphabet check: radix in range, no sign symbols, no repeats among the
  // first radix symbols. Pairwise compares run in parallel.
  always_comb begin
    alpha_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < radix) begin
        if (symbol_at(alpha, DIGIT_W'(i)) == SIGN_PLUS ||
            symbol_at(alpha, DIGIT_W'(i)) == SIGN_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < radix &&
              symbol_at(alpha, DIGIT_W'(i)) == symbol_at(alpha, DIGIT_W'(j))) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign neg      = value[VALUE_W-1];
  assign mag      = neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

  // start a digit on a fresh request or keep going while quotient is nonzero
  assign div_start    = (accept && alpha_ok) ||
                        (state == S_DIV && div_st.done && !div_st.quo_zero);
  assign div_dividend = (state == S_IDLE) ? mag : div_quo;
  assign push         = (state == S_DIV) && div_st.done;

  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);
  assign pop      = out_load && !sign_pend;

  srf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .base     (radix),
    .quotient (div_quo),
    .status   (div_st)
  );

  srf_digit_stack u_stack (
    .clk  (clk),
    .push (push),
    .pop  (pop),
    .din  (div_st.digit),
    .dout (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && alpha_ok) begin
            state     <= S_DIV;
            sign_pend <= neg;
            cnt       <= '0;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            cnt <= cnt + 1'b1;
            if (div_st.quo_zero) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else begin
              cnt <= cnt - 1'b1;
              if (cnt == CNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sign_pend) begin
        symbol <= SIGN_MINUS;
        last   <= 1'b0;
      end else begin
        symbol <= symbol_at(alpha, top_digit);
        last   <= (cnt == CNT_W'(1));
      end
    end
  end

  // digit count never runs past the stack depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

  // emitting always has something left to send
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> (cnt != '0 || sign_pend))
    else $error("emit with empty stack");

  // divider finishes only while a conversion is running
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("stray divider done");

  // the minus sign is never the final symbol
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && symbol == SIGN_MINUS) |-> !last)
    else $error("sign marked last");

  // loading the final digit returns the block to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && cnt == CNT_W'(1)) |=> state == S_IDLE && out_valid && last)
    else $error("final digit did not end request");

endmodule
